@@ rtl/pia_pkg.sv @@
// Package for the pool index allocator.
// Holds shared types, status and command codes, and default sizes.
// No dependencies.
package pia_pkg;

    localparam int DEF_POOL_SLOTS = 256;
    localparam int IDX_W          = 8;
    localparam int CFG_W          = 9;
    localparam int IDX_RANGE      = 256;
    localparam logic [CFG_W-1:0] POOL_SIZE_RST = 9'd256;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        STAT_GRANTED   = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_REL_OK    = 2'd2,
        STAT_REL_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    // Fresh counter status toward the control logic
    typedef struct packed {
        logic             avail;
        logic [IDX_W-1:0] idx;
    } t_fresh_stat;

endpackage

@@ rtl/pia_queue_ram.sv @@
// Free queue storage for the pool index allocator.
// One write port, one read port with registered read data. Uses pia_pkg.
module pia_queue_ram
    import pia_pkg::*;
#(
    parameter int DEPTH = DEF_POOL_SLOTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [IDX_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [IDX_W-1:0] o_rdata
);

    logic [IDX_W-1:0] r_mem [DEPTH];
    logic [IDX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pia_fresh_ctr.sv @@
// Fresh index counter for the pool index allocator.
// Saturates at the smaller of pool size, index range and pool slots. Uses pia_pkg.
module pia_fresh_ctr
    import pia_pkg::*;
#(
    parameter int POOL_SLOTS = DEF_POOL_SLOTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_pool_size,
    input  logic             i_advance,
    output t_fresh_stat      o_stat
);

    localparam int LIM_CAP = (POOL_SLOTS < IDX_RANGE) ? POOL_SLOTS : IDX_RANGE;
    localparam logic [CFG_W-1:0] LIM_CAP_V = CFG_W'(LIM_CAP);

    logic [CFG_W-1:0] r_fresh;
    logic [CFG_W-1:0] n_fresh;
    logic [CFG_W-1:0] limit;

    assign limit = (i_pool_size < LIM_CAP_V) ? i_pool_size : LIM_CAP_V;

    assign o_stat.avail = (r_fresh < limit);
    assign o_stat.idx   = r_fresh[IDX_W-1:0];

    // Advance only when an index is actually handed out
    assign n_fresh = (i_advance && o_stat.avail) ? r_fresh + CFG_W'(1) : r_fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= '0;
        end else begin
            r_fresh <= n_fresh;
        end
    end

endmodule

@@ rtl/pool_index_allocator.sv @@
// Top level of the pool index allocator: command port, config register, control.
// Instantiates pia_queue_ram and pia_fresh_ctr; uses pia_pkg.
//
// Usage: present a request with start high while busy is low; it is taken at
// that clock edge. Each request yields exactly one result, shown on o_status
// and o_granted_index for one cycle with o_strobe high; the receiver cannot
// stall, so sample it then. Releases, allocations served by the fresh counter
// and exhausted allocations need no queue read: the result appears the cycle after
// the request and a new request may follow at once. An allocation served from
// the free queue goes through the registered read port of the queue memory and
// the ST_READ state: busy is high for one cycle and the result is registered
// from the read data. The pool size register may be written at any time
// through the cfg channel (always ready); write it only while no request is
// in flight. The free queue memory has no reset and needs no clearing pass.
module pool_index_allocator
    import pia_pkg::*;
#(
    parameter int POOL_SLOTS = DEF_POOL_SLOTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_cmd,
    input  logic [IDX_W-1:0] i_released_index,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [IDX_W-1:0] o_granted_index,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int PTR_W = $clog2(POOL_SLOTS);
    localparam int CNT_W = $clog2(POOL_SLOTS + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(POOL_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_SLOTS);

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_pool_size;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    logic [IDX_W-1:0] r_granted, n_granted;

    logic             accept;
    logic             q_empty;
    logic             q_full;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_rdata;
    logic             fresh_adv;
    t_fresh_stat      fresh;

    // Config register: always ready, written directly
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= POOL_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pool_size <= i_cfg_data;
        end
    end

    // Hold off new requests while a queue read is in flight
    assign busy    = (r_state == ST_READ);
    assign accept  = start && !busy;
    assign q_empty = (r_count == '0);
    assign q_full  = (r_count == CNT_FULL);

    assign mem_re    = accept && (i_cmd == CMD_ALLOC) && !q_empty;
    assign mem_we    = accept && (i_cmd == CMD_RELEASE) && !q_full;
    assign fresh_adv = accept && (i_cmd == CMD_ALLOC) && q_empty;

    pia_queue_ram #(
        .DEPTH (POOL_SLOTS),
        .AW    (PTR_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_tail),
        .i_wdata (i_released_index),
        .i_re    (mem_re),
        .i_raddr (r_head),
        .o_rdata (mem_rdata)
    );

    pia_fresh_ctr #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_fresh (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pool_size (r_pool_size),
        .i_advance   (fresh_adv),
        .o_stat      (fresh)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = 1'b0;
        n_status    = r_status;
        n_granted   = r_granted;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_ALLOC) begin
                        if (!q_empty) begin
                            // Pop: read is issued now, result follows the read
                            n_head  = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
                            n_count = r_count - CNT_W'(1);
                            n_state = ST_READ;
                        end else if (fresh.avail) begin
                            n_out_valid = 1'b1;
                            n_status    = STAT_GRANTED;
                            n_granted   = fresh.idx;
                        end else begin
                            n_out_valid = 1'b1;
                            n_status    = STAT_EXHAUSTED;
                            n_granted   = '0;
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        n_granted   = '0;
                        if (q_full) begin
                            // Drop the index
                            n_status = STAT_REL_FULL;
                        end else begin
                            n_tail   = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
                            n_count  = r_count + CNT_W'(1);
                            n_status = STAT_REL_OK;
                        end
                    end
                end
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_status    = STAT_GRANTED;
                n_granted   = mem_rdata;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    assign o_strobe        = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_index = r_granted;

    // A queue read always ends in a grant on the next cycle
    a_read_grants: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (o_strobe && o_status == STAT_GRANTED))
        else $error("queue read did not produce a grant");

    // Requests that skip the queue read answer on the next cycle
    a_direct_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !mem_re) |=> o_strobe)
        else $error("request without queue read gave no result");

    // Non-grant results carry a zero index
    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != STAT_GRANTED) |-> (o_granted_index == '0))
        else $error("non-grant result with nonzero index");

    // Fill count stays within the queue depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_FULL))
        else $error("free queue count overflow");

    // Memory read and write never coincide
    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_re && mem_we))
        else $error("queue read and write in the same cycle");

endmodule
